// ===== hw/rtl/ghp_pkg.sv =====
// ----------------------------------------------------------------------------
// ghp_pkg
// Shared types, codes and the byte-wide crc-32 update for the gzip header
// parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ghp_pkg;

    // byte counter width, its increment and its saturation value
    localparam int COUNT_WIDTH = 20;
    localparam logic [COUNT_WIDTH-1:0] COUNT_ONE   = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = {COUNT_WIDTH{1'b1}};

    // reflected crc-32
    localparam logic [31:0] CRC_POLY = 32'hedb88320;
    localparam logic [31:0] CRC_INIT = 32'hffffffff;

    // fixed header constants
    localparam logic [7:0] MAGIC_ID1      = 8'h1f;
    localparam logic [7:0] MAGIC_ID2      = 8'h8b;
    localparam logic [7:0] METHOD_DEFLATE = 8'd8;
    localparam logic [7:0] FLAG_RESERVED  = 8'he0;
    localparam logic [3:0] FIXED_LEN      = 4'd10;

    // flag bit positions
    localparam int FLAG_HCRC_BIT    = 1;
    localparam int FLAG_EXTRA_BIT   = 2;
    localparam int FLAG_NAME_BIT    = 3;
    localparam int FLAG_COMMENT_BIT = 4;

    // fixed byte positions
    localparam logic [3:0] IDX_ID1    = 4'd0;
    localparam logic [3:0] IDX_ID2    = 4'd1;
    localparam logic [3:0] IDX_METHOD = 4'd2;
    localparam logic [3:0] IDX_FLAGS  = 4'd3;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_METHOD    = 3'd2,
        ST_TRUNC     = 3'd3,
        ST_CRC       = 3'd4
    } status_t;

    // walker phases, one-hot
    typedef enum logic [8:0] {
        PH_FIXED    = 9'b000000001,
        PH_XLEN_LO  = 9'b000000010,
        PH_XLEN_HI  = 9'b000000100,
        PH_EXTRA    = 9'b000001000,
        PH_NAME     = 9'b000010000,
        PH_COMMENT  = 9'b000100000,
        PH_CRC_LO   = 9'b001000000,
        PH_CRC_HI   = 9'b010000000,
        PH_FINISHED = 9'b100000000
    } phase_t;

    // what the walker hands back for one byte
    typedef struct packed {
        logic        fire;
        status_t     status;
        logic [19:0] header_bytes;
        logic [7:0]  member_flags;
    } ghp_result_t;

    // one byte through the reflected crc-32
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ghp_walker.sv =====
// ----------------------------------------------------------------------------
// ghp_walker
// Header walker state and its per-word update: fixed byte checks, extra
// field skip, name and comment skip, header crc compare.
// ----------------------------------------------------------------------------
`default_nettype none

module ghp_walker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        data_byte,
    input  wire logic              is_last,
    input  wire logic              restart,
    output ghp_pkg::ghp_result_t   result
);

    ghp_pkg::phase_t                 phase_reg, phase_next;
    logic [3:0]                      fixed_index_reg, fixed_index_next;
    logic [7:0]                      flag_store_reg, flag_store_next;
    logic [1:0]                      check_bits_reg, check_bits_next;
    logic [15:0]                     extra_left_reg, extra_left_next;
    logic [31:0]                     crc_accum_reg, crc_accum_next;
    logic [7:0]                      crc_first_reg, crc_first_next;
    logic [ghp_pkg::COUNT_WIDTH-1:0] byte_total_reg, byte_total_next;

    // state as seen by this word, after an optional restart
    ghp_pkg::phase_t                 cur_phase;
    logic [3:0]                      cur_index;
    logic [7:0]                      cur_flags;
    logic [1:0]                      cur_check;
    logic [15:0]                     cur_extra;
    logic [31:0]                     cur_crc;
    logic [7:0]                      cur_first;
    logic [ghp_pkg::COUNT_WIDTH-1:0] cur_total;

    logic              live;
    logic              crc_live;
    logic              have_status;
    ghp_pkg::status_t  status_code;

    // next optional section after a given point; rank 0 fixed, 1 extra,
    // 2 name, 3 comment
    function automatic ghp_pkg::phase_t after_section(input logic [7:0] f,
                                                      input logic [1:0] rank);
        ghp_pkg::phase_t p;
        p = ghp_pkg::PH_FINISHED;
        if (f[ghp_pkg::FLAG_HCRC_BIT])
            p = ghp_pkg::PH_CRC_LO;
        if (rank <= 2'd2 && f[ghp_pkg::FLAG_COMMENT_BIT])
            p = ghp_pkg::PH_COMMENT;
        if (rank <= 2'd1 && f[ghp_pkg::FLAG_NAME_BIT])
            p = ghp_pkg::PH_NAME;
        if (rank == 2'd0 && f[ghp_pkg::FLAG_EXTRA_BIT])
            p = ghp_pkg::PH_XLEN_LO;
        return p;
    endfunction

    // restart makes this word the first header byte
    always_comb
    begin
        if (restart)
        begin
            cur_phase = ghp_pkg::PH_FIXED;
            cur_index = 4'd0;
            cur_flags = 8'd0;
            cur_check = 2'b00;
            cur_extra = 16'd0;
            cur_crc   = ghp_pkg::CRC_INIT;
            cur_first = 8'd0;
            cur_total = '0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_index = fixed_index_reg;
            cur_flags = flag_store_reg;
            cur_check = check_bits_reg;
            cur_extra = extra_left_reg;
            cur_crc   = crc_accum_reg;
            cur_first = crc_first_reg;
            cur_total = byte_total_reg;
        end
    end

    // which phases take a word and which feed the crc
    always_comb
    begin
        case (cur_phase)
            ghp_pkg::PH_FIXED, ghp_pkg::PH_XLEN_LO, ghp_pkg::PH_XLEN_HI,
            ghp_pkg::PH_EXTRA, ghp_pkg::PH_NAME, ghp_pkg::PH_COMMENT:
            begin
                live     = 1'b1;
                crc_live = 1'b1;
            end
            ghp_pkg::PH_CRC_LO, ghp_pkg::PH_CRC_HI:
            begin
                live     = 1'b1;
                crc_live = 1'b0;
            end
            default:
            begin
                live     = 1'b0;
                crc_live = 1'b0;
            end
        endcase
    end

    // per-word update
    always_comb
    begin
        phase_next       = cur_phase;
        fixed_index_next = cur_index;
        flag_store_next  = cur_flags;
        check_bits_next  = cur_check;
        extra_left_next  = cur_extra;
        crc_accum_next   = cur_crc;
        crc_first_next   = cur_first;
        byte_total_next  = cur_total;
        have_status      = 1'b0;
        status_code      = ghp_pkg::ST_OK;

        if (live)
        begin
            // saturating header byte count and running crc
            if (cur_total != ghp_pkg::COUNT_LIMIT)
                byte_total_next = cur_total + ghp_pkg::COUNT_ONE;
            if (crc_live)
                crc_accum_next = ghp_pkg::crc_byte(cur_crc, data_byte);

            case (cur_phase)
                ghp_pkg::PH_FIXED:
                begin
                    if (cur_index == ghp_pkg::IDX_ID1 && data_byte != ghp_pkg::MAGIC_ID1)
                        check_bits_next[0] = 1'b1;
                    if (cur_index == ghp_pkg::IDX_ID2 && data_byte != ghp_pkg::MAGIC_ID2)
                        check_bits_next[0] = 1'b1;
                    if (cur_index == ghp_pkg::IDX_METHOD
                        && data_byte != ghp_pkg::METHOD_DEFLATE)
                        check_bits_next[1] = 1'b1;
                    if (cur_index == ghp_pkg::IDX_FLAGS)
                    begin
                        flag_store_next = data_byte;
                        if ((data_byte & ghp_pkg::FLAG_RESERVED) != 8'd0)
                            check_bits_next[0] = 1'b1;
                    end
                    fixed_index_next = cur_index + 4'd1;
                    // errors only at the tenth byte, magic or flags first
                    if (fixed_index_next >= ghp_pkg::FIXED_LEN)
                    begin
                        if (check_bits_next[0])
                        begin
                            have_status = 1'b1;
                            status_code = ghp_pkg::ST_BAD_MAGIC;
                        end
                        else if (check_bits_next[1])
                        begin
                            have_status = 1'b1;
                            status_code = ghp_pkg::ST_METHOD;
                        end
                        else
                        begin
                            phase_next = after_section(flag_store_next, 2'd0);
                        end
                    end
                end
                ghp_pkg::PH_XLEN_LO:
                begin
                    extra_left_next = {8'd0, data_byte};
                    phase_next      = ghp_pkg::PH_XLEN_HI;
                end
                ghp_pkg::PH_XLEN_HI:
                begin
                    extra_left_next = {data_byte, cur_extra[7:0]};
                    if (extra_left_next == 16'd0)
                        phase_next = after_section(cur_flags, 2'd1);
                    else
                        phase_next = ghp_pkg::PH_EXTRA;
                end
                ghp_pkg::PH_EXTRA:
                begin
                    extra_left_next = cur_extra - 16'd1;
                    if (extra_left_next == 16'd0)
                        phase_next = after_section(cur_flags, 2'd1);
                end
                ghp_pkg::PH_NAME:
                begin
                    if (data_byte == 8'd0)
                        phase_next = after_section(cur_flags, 2'd2);
                end
                ghp_pkg::PH_COMMENT:
                begin
                    if (data_byte == 8'd0)
                        phase_next = after_section(cur_flags, 2'd3);
                end
                ghp_pkg::PH_CRC_LO:
                begin
                    crc_first_next = data_byte;
                    phase_next     = ghp_pkg::PH_CRC_HI;
                end
                ghp_pkg::PH_CRC_HI:
                begin
                    if ((~cur_crc[15:0]) != {data_byte, cur_first})
                    begin
                        have_status = 1'b1;
                        status_code = ghp_pkg::ST_CRC;
                    end
                    else
                    begin
                        phase_next = ghp_pkg::PH_FINISHED;
                    end
                end
                default:
                begin
                end
            endcase

            // complete header, else truncation on the last byte
            if (!have_status && phase_next == ghp_pkg::PH_FINISHED)
            begin
                have_status = 1'b1;
                status_code = ghp_pkg::ST_OK;
            end
            if (!have_status && is_last)
            begin
                have_status = 1'b1;
                status_code = ghp_pkg::ST_TRUNC;
            end
            if (have_status)
                phase_next = ghp_pkg::PH_FINISHED;
        end
    end

    // outcome for this word
    assign result.fire         = live && have_status;
    assign result.status       = status_code;
    assign result.header_bytes = 20'(byte_total_next);
    assign result.member_flags = flag_store_next;

    // walker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= ghp_pkg::PH_FIXED;
            fixed_index_reg <= 4'd0;
            flag_store_reg  <= 8'd0;
            check_bits_reg  <= 2'b00;
            extra_left_reg  <= 16'd0;
            crc_accum_reg   <= ghp_pkg::CRC_INIT;
            crc_first_reg   <= 8'd0;
            byte_total_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            fixed_index_reg <= fixed_index_next;
            flag_store_reg  <= flag_store_next;
            check_bits_reg  <= check_bits_next;
            extra_left_reg  <= extra_left_next;
            crc_accum_reg   <= crc_accum_next;
            crc_first_reg   <= crc_first_next;
            byte_total_reg  <= byte_total_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gzip_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// gzip_header_parser_unit
// Walks a gzip member header one byte per word and reports one outcome.
// ----------------------------------------------------------------------------
//  channel | handshake            | fields
//  --------+----------------------+-------------------------------------
//  input   | in_valid, in_stall   | data_byte, is_last, restart
//  output  | out_valid, out_stall | status, header_bytes, member_flags
//
//  one byte per cycle sustained while in_stall stays low; a byte goes into the
//  input register when taken, and its result is loaded into the result register
//  when it advances; a byte that gives no result moves on even while a result waits
//  in_stall rises only when the held byte would give a result and the result
//  register is full and stalled
//  rst_n clears all control state at once; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module gzip_header_parser_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        is_last,
    input  wire logic        restart,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [19:0]      header_bytes,
    output logic [7:0]       member_flags
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] data_reg;
    logic       last_reg;
    logic       restart_reg;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  status_reg;
    logic [19:0] header_bytes_reg;
    logic [7:0]  member_flags_reg;

    ghp_pkg::ghp_result_t result;
    logic                 out_free;
    logic                 advance;

    // the walker
    ghp_walker u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (data_reg),
        .is_last   (last_reg),
        .restart   (restart_reg),
        .result    (result)
    );

    // flow control
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && (!result.fire || out_free);
    assign in_stall = in_valid_reg && !advance;

    // input register
    assign in_valid_next = in_stall ? in_valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            data_reg    <= data_byte;
            last_reg    <= is_last;
            restart_reg <= restart;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (advance && result.fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.fire)
        begin
            status_reg       <= result.status;
            header_bytes_reg <= result.header_bytes;
            member_flags_reg <= result.member_flags;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign header_bytes = header_bytes_reg;
    assign member_flags = member_flags_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ghp_checker.sv =====
// ----------------------------------------------------------------------------
// ghp_checker
// Port-level checks for the gzip header parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ghp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic [7:0]  data_byte,
    input wire logic        is_last,
    input wire logic        restart,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  status,
    input wire logic [19:0] header_bytes,
    input wire logic [7:0]  member_flags
);

    // a stalled input word stays
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(data_byte)
            && $stable(is_last) && $stable(restart))
        else $error("input word changed while stalled");

    // a stalled result word stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(header_bytes) && $stable(member_flags))
        else $error("result word changed while stalled");

    // input backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with the result side free");

    // status codes in range
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ghp_pkg::ST_OK || status == ghp_pkg::ST_BAD_MAGIC
            || status == ghp_pkg::ST_METHOD || status == ghp_pkg::ST_TRUNC
            || status == ghp_pkg::ST_CRC)
        else $error("status code out of range");

    // fixed header errors are reported at the tenth byte
    a_fixed_err_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ghp_pkg::ST_BAD_MAGIC || status == ghp_pkg::ST_METHOD)
            |-> header_bytes == 20'd10)
        else $error("fixed header error at wrong byte count");

endmodule

bind gzip_header_parser_unit ghp_checker u_ghp_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_gzip_header_parser_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gzip_header_parser_unit
// Self-checking bench for the gzip header parser. Gzip member headers are
// built byte by byte: well-formed ones with random extra, name, comment and
// header crc, plus broken magic, method, reserved flags, truncation, bad crc
// and loose noise. A predictor walks each accepted word and queues the
// outcome, and the monitor checks each result against it. The input idles
// and the output stalls at random.
// ----------------------------------------------------------------------------

module tb_gzip_header_parser_unit;

    // one input word as queued for the driver
    typedef struct {
        logic [7:0] data;
        logic       fin;
        logic       rs;
        bit         hold_for_drain;
    } stream_word_t;

    // one predicted parser outcome
    typedef struct {
        ghp_pkg::status_t status;
        logic [19:0]      header_bytes;
        logic [7:0]       member_flags;
    } hdr_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'd0;
    logic        is_last = 1'b0;
    logic        restart = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [19:0] header_bytes;
    logic [7:0]  member_flags;

    stream_word_t pending_words[$];
    hdr_result_t  expected_results[$];
    hdr_result_t  got_result;
    hdr_result_t  want;
    stream_word_t next_word;

    int error_count = 0;
    int words_queued = 0;
    int words_accepted = 0;
    int send_gap = 0;
    int stall_left = 0;
    int calm_left[2] = '{0, 0};

    // predictor state
    ghp_pkg::phase_t                 walk_phase;
    logic [3:0]                      fixed_pos;
    logic [7:0]                      seen_flags;
    logic [1:0]                      fault_bits;
    logic [15:0]                     extra_count;
    logic [31:0]                     crc_run;
    logic [7:0]                      crc_lo_byte;
    logic [ghp_pkg::COUNT_WIDTH-1:0] hdr_count;

    gzip_header_parser_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .is_last      (is_last),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .header_bytes (header_bytes),
        .member_flags (member_flags)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic log_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // reflected crc-32, one data bit at a time
    function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        r = c;
        for (int n = 0; n < 8; n++)
        begin
            if (r[0] ^ d[n])
                r = (r >> 1) ^ ghp_pkg::CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    function automatic void reset_walker();
        walk_phase  = ghp_pkg::PH_FIXED;
        fixed_pos   = 4'd0;
        seen_flags  = 8'd0;
        fault_bits  = 2'b00;
        extra_count = 16'd0;
        crc_run     = ghp_pkg::CRC_INIT;
        crc_lo_byte = 8'd0;
        hdr_count   = '0;
    endfunction

    // next optional field after phase p, per the member flags
    function automatic ghp_pkg::phase_t after_phase(input ghp_pkg::phase_t p);
        if (p < ghp_pkg::PH_XLEN_LO && seen_flags[ghp_pkg::FLAG_EXTRA_BIT])
            return ghp_pkg::PH_XLEN_LO;
        if (p < ghp_pkg::PH_NAME && seen_flags[ghp_pkg::FLAG_NAME_BIT])
            return ghp_pkg::PH_NAME;
        if (p < ghp_pkg::PH_COMMENT && seen_flags[ghp_pkg::FLAG_COMMENT_BIT])
            return ghp_pkg::PH_COMMENT;
        if (p < ghp_pkg::PH_CRC_LO && seen_flags[ghp_pkg::FLAG_HCRC_BIT])
            return ghp_pkg::PH_CRC_LO;
        return ghp_pkg::PH_FINISHED;
    endfunction

    // walk one accepted word; returns 1 when it yields an outcome
    function automatic bit walk_header_byte(input logic [7:0] b, input logic fin,
                                            input logic rs, output hdr_result_t r);
        bit               done;
        ghp_pkg::status_t st;
        done = 1'b0;
        st   = ghp_pkg::ST_OK;
        r.status       = ghp_pkg::ST_OK;
        r.header_bytes = '0;
        r.member_flags = '0;
        if (rs)
            reset_walker();
        if (walk_phase == ghp_pkg::PH_FINISHED)
            return 1'b0;
        if (hdr_count != ghp_pkg::COUNT_LIMIT)
            hdr_count++;
        if (walk_phase <= ghp_pkg::PH_COMMENT)
            crc_run = crc32_step(crc_run, b);

        case (walk_phase)
            ghp_pkg::PH_FIXED:
            begin
                if (fixed_pos == ghp_pkg::IDX_ID1 && b != ghp_pkg::MAGIC_ID1)
                    fault_bits[0] = 1'b1;
                if (fixed_pos == ghp_pkg::IDX_ID2 && b != ghp_pkg::MAGIC_ID2)
                    fault_bits[0] = 1'b1;
                if (fixed_pos == ghp_pkg::IDX_METHOD && b != ghp_pkg::METHOD_DEFLATE)
                    fault_bits[1] = 1'b1;
                if (fixed_pos == ghp_pkg::IDX_FLAGS)
                begin
                    seen_flags = b;
                    if ((b & ghp_pkg::FLAG_RESERVED) != 8'd0)
                        fault_bits[0] = 1'b1;
                end
                fixed_pos = fixed_pos + 4'd1;
                if (fixed_pos >= ghp_pkg::FIXED_LEN)
                begin
                    // magic or reserved-flag error wins over method error
                    if (fault_bits[0])
                    begin
                        done = 1'b1;
                        st   = ghp_pkg::ST_BAD_MAGIC;
                    end
                    else if (fault_bits[1])
                    begin
                        done = 1'b1;
                        st   = ghp_pkg::ST_METHOD;
                    end
                    else
                        walk_phase = after_phase(ghp_pkg::PH_FIXED);
                end
            end
            ghp_pkg::PH_XLEN_LO:
            begin
                extra_count = {8'd0, b};
                walk_phase  = ghp_pkg::PH_XLEN_HI;
            end
            ghp_pkg::PH_XLEN_HI:
            begin
                extra_count = {b, extra_count[7:0]};
                walk_phase  = (extra_count == 16'd0) ? after_phase(ghp_pkg::PH_EXTRA)
                                                     : ghp_pkg::PH_EXTRA;
            end
            ghp_pkg::PH_EXTRA:
            begin
                extra_count = extra_count - 16'd1;
                if (extra_count == 16'd0)
                    walk_phase = after_phase(ghp_pkg::PH_EXTRA);
            end
            ghp_pkg::PH_NAME, ghp_pkg::PH_COMMENT:
            begin
                if (b == 8'd0)
                    walk_phase = after_phase(walk_phase);
            end
            ghp_pkg::PH_CRC_LO:
            begin
                crc_lo_byte = b;
                walk_phase  = ghp_pkg::PH_CRC_HI;
            end
            ghp_pkg::PH_CRC_HI:
            begin
                if ((~crc_run[15:0]) != {b, crc_lo_byte})
                begin
                    done = 1'b1;
                    st   = ghp_pkg::ST_CRC;
                end
                else
                    walk_phase = ghp_pkg::PH_FINISHED;
            end
            default:
            begin
            end
        endcase

        if (!done && walk_phase == ghp_pkg::PH_FINISHED)
        begin
            done = 1'b1;
            st   = ghp_pkg::ST_OK;
        end
        if (!done && fin)
        begin
            done = 1'b1;
            st   = ghp_pkg::ST_TRUNC;
        end
        if (!done)
            return 1'b0;
        walk_phase     = ghp_pkg::PH_FINISHED;
        r.status       = st;
        r.header_bytes = 20'(hdr_count);
        r.member_flags = seen_flags;
        return 1'b1;
    endfunction

    // idle length: mostly none, some short, a few long, with calm stretches
    function automatic int pick_idle(input int side);
        int roll;
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            calm_left[side] = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 60)
            return 0;
        if (roll < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [31:0] r;
        r = $urandom;
        return r[7:0];
    endfunction

    function automatic logic [7:0] rand_text();
        logic [31:0] r;
        r = $urandom_range(1, 255);
        return r[7:0];
    endfunction

    task automatic add_word(input logic [7:0] d, input logic fin, input logic rs,
                            input bit hold);
        stream_word_t w;
        w.data           = d;
        w.fin            = fin;
        w.rs             = rs;
        w.hold_for_drain = hold;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // build one member header and queue its words; keep < 0 sends it whole
    task automatic emit_member(input logic [7:0] id1, input logic [7:0] id2,
                               input logic [7:0] method, input logic [7:0] flags,
                               input int xlen, input int nlen, input int clen,
                               input bit crc_good, input int keep, input bit keep_last,
                               input bit last_at_end, input int tail_len,
                               input bit rs_first, input bit hold);
        logic [7:0]  hdr[$];
        logic [31:0] crc;
        logic [15:0] stored;
        int          cap;
        int          n_out;
        int          k;
        cap = (keep >= 0) ? keep : 32'h7fffffff;
        hdr.push_back(id1);
        hdr.push_back(id2);
        hdr.push_back(method);
        hdr.push_back(flags);
        repeat (6) hdr.push_back(rand_byte());
        if (flags[ghp_pkg::FLAG_EXTRA_BIT])
        begin
            hdr.push_back(xlen[7:0]);
            hdr.push_back(xlen[15:8]);
            for (k = 0; k < xlen && hdr.size() < cap; k++)
                hdr.push_back(rand_byte());
        end
        if (flags[ghp_pkg::FLAG_NAME_BIT])
        begin
            repeat (nlen) hdr.push_back(rand_text());
            hdr.push_back(8'd0);
        end
        if (flags[ghp_pkg::FLAG_COMMENT_BIT])
        begin
            repeat (clen) hdr.push_back(rand_text());
            hdr.push_back(8'd0);
        end
        // header crc word, optionally with one bit flipped
        if (flags[ghp_pkg::FLAG_HCRC_BIT])
        begin
            crc = ghp_pkg::CRC_INIT;
            foreach (hdr[j])
                crc = crc32_step(crc, hdr[j]);
            stored = ~crc[15:0];
            if (!crc_good)
            begin
                k = $urandom_range(0, 15);
                stored[k] = ~stored[k];
            end
            hdr.push_back(stored[7:0]);
            hdr.push_back(stored[15:8]);
        end
        n_out = (keep >= 0 && keep < hdr.size()) ? keep : hdr.size();
        for (k = 0; k < n_out; k++)
            add_word(hdr[k],
                     (k == n_out - 1) && ((keep >= 0) ? keep_last
                                                       : (last_at_end && tail_len == 0)),
                     rs_first && k == 0, hold && k == 0);
        // trailing body bytes, ignored unless the header is still open
        for (k = 0; k < tail_len; k++)
            add_word(rand_byte(), (k == tail_len - 1) && last_at_end, 1'b0, 1'b0);
    endtask

    // driver: present queued words, predict each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                words_accepted++;
                if (walk_header_byte(data_byte, is_last, restart, got_result))
                    expected_results.push_back(got_result);
            end
            if (in_valid && in_stall)
            begin
                // hold the stalled word
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_words.size() > 0 &&
                     !(pending_words[0].hold_for_drain && expected_results.size() > 0))
            begin
                next_word = pending_words.pop_front();
                in_valid  <= 1'b1;
                data_byte <= next_word.data;
                is_last   <= next_word.fin;
                restart   <= next_word.rs;
                send_gap  = pick_idle(0);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor: check each taken result, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    log_error($sformatf("unexpected result status %0d bytes %0d flags %02h",
                                        status, header_bytes, member_flags));
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        log_error($sformatf("status %0d, expected %0d", status, want.status));
                    if (header_bytes !== want.header_bytes)
                        log_error($sformatf("header_bytes %0d, expected %0d",
                                            header_bytes, want.header_bytes));
                    if (member_flags !== want.member_flags)
                        log_error($sformatf("member_flags %02h, expected %02h",
                                            member_flags, want.member_flags));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = pick_idle(1);
                out_stall <= 1'b0;
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        int         roll;
        int         sub;
        int         xlen;
        int         keep;
        int         n;
        bit         kl;
        logic [7:0] fl;
        logic [7:0] i1;
        logic [7:0] i2;
        logic [7:0] mth;

        reset_walker();

        // directed: plain header straight after reset, no restart
        emit_member(ghp_pkg::MAGIC_ID1, ghp_pkg::MAGIC_ID2, ghp_pkg::METHOD_DEFLATE, 8'h00,
                    0, 0, 0, 1, -1, 0, 1, 0, 0, 0);
        // bad first id, then ignored bytes ending with is_last
        emit_member(8'h00, ghp_pkg::MAGIC_ID2, ghp_pkg::METHOD_DEFLATE, 8'h00,
                    0, 0, 0, 1, -1, 0, 1, 2, 1, 0);
        // unsupported method
        emit_member(ghp_pkg::MAGIC_ID1, ghp_pkg::MAGIC_ID2, 8'h07, 8'h00,
                    0, 0, 0, 1, -1, 0, 0, 0, 1, 0);
        // bad second id and bad method: magic error wins
        emit_member(ghp_pkg::MAGIC_ID1, 8'hff, 8'hff, 8'h00, 0, 0, 0, 1, -1, 0, 0, 0, 1, 0);
        // every flag set, reserved ones among them
        emit_member(ghp_pkg::MAGIC_ID1, ghp_pkg::MAGIC_ID2, ghp_pkg::METHOD_DEFLATE, 8'hff,
                    0, 0, 0, 1, -1, 0, 0, 0, 1, 0);
        // truncated before the tenth byte despite errors
        emit_member(8'hff, 8'h00, 8'h00, 8'h00, 0, 0, 0, 1, 3, 1, 0, 0, 1, 0);
        // all optional fields, zero extra length, empty strings, good crc; sender drains first
        emit_member(ghp_pkg::MAGIC_ID1, ghp_pkg::MAGIC_ID2, ghp_pkg::METHOD_DEFLATE, 8'h1f,
                    0, 0, 0, 1, -1, 0, 1, 0, 1, 1);
        // extra field with bad header crc
        emit_member(ghp_pkg::MAGIC_ID1, ghp_pkg::MAGIC_ID2, ghp_pkg::METHOD_DEFLATE, 8'h06,
                    3, 0, 0, 0, -1, 0, 0, 0, 1, 0);
        // maximum extra length, cut short with is_last
        emit_member(ghp_pkg::MAGIC_ID1, ghp_pkg::MAGIC_ID2, ghp_pkg::METHOD_DEFLATE, 8'h04,
                    65535, 0, 0, 1, 16, 1, 0, 0, 1, 0);
        // name abandoned mid-way, then restart into a full header
        emit_member(ghp_pkg::MAGIC_ID1, ghp_pkg::MAGIC_ID2, ghp_pkg::METHOD_DEFLATE, 8'h08,
                    0, 3, 0, 1, 12, 0, 0, 0, 1, 0);
        emit_member(ghp_pkg::MAGIC_ID1, ghp_pkg::MAGIC_ID2, ghp_pkg::METHOD_DEFLATE, 8'h1e,
                    2, 2, 2, 1, -1, 0, 1, 0, 1, 0);

        // random part
        while (words_queued < 540)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                // well-formed member with random content
                fl   = rand_byte() & 8'h1f;
                sub  = $urandom_range(0, 9);
                xlen = 0;
                keep = -1;
                kl   = 1'b0;
                if (sub >= 2 && sub <= 7)
                    xlen = $urandom_range(1, 12);
                else if (sub == 8)
                    xlen = $urandom_range(13, 80);
                else if (sub == 9)
                begin
                    xlen = $urandom_range(256, 65535);
                    fl[ghp_pkg::FLAG_EXTRA_BIT] = 1'b1;
                    keep = 12 + $urandom_range(1, 24);
                    kl   = ($urandom_range(0, 3) != 0);
                end
                if (keep < 0)
                begin
                    n = $urandom_range(0, 99);
                    if (n < 12)
                    begin
                        keep = $urandom_range(1, 14);
                        kl   = 1'b1;
                    end
                    else if (n < 16)
                        keep = $urandom_range(1, 14);
                end
                emit_member(ghp_pkg::MAGIC_ID1, ghp_pkg::MAGIC_ID2, ghp_pkg::METHOD_DEFLATE,
                            fl, xlen,
                            $urandom_range(0, 6), $urandom_range(0, 6),
                            $urandom_range(0, 9) != 0, keep, kl,
                            $urandom_range(0, 2) == 0, $urandom_range(0, 2), 1'b1,
                            $urandom_range(0, 49) == 0);
            end
            else if (roll < 80)
            begin
                // corrupted fixed fields
                i1  = ($urandom_range(0, 9) < 4) ? rand_byte() : ghp_pkg::MAGIC_ID1;
                i2  = ($urandom_range(0, 9) < 4) ? rand_byte() : ghp_pkg::MAGIC_ID2;
                mth = ($urandom_range(0, 9) < 4) ? rand_byte() : ghp_pkg::METHOD_DEFLATE;
                emit_member(i1, i2, mth, rand_byte(), $urandom_range(0, 4),
                            $urandom_range(0, 2), $urandom_range(0, 2), 1'b1, -1, 1'b0,
                            $urandom_range(0, 1), $urandom_range(0, 2), 1'b1, 1'b0);
            end
            else if (roll < 90)
            begin
                // loose noise words
                n = $urandom_range(1, 6);
                repeat (n)
                    add_word(rand_byte(), $urandom_range(0, 9) == 0,
                             $urandom_range(0, 9) == 0, 1'b0);
            end
            else
            begin
                // any flag byte, reserved bits included
                emit_member(ghp_pkg::MAGIC_ID1, ghp_pkg::MAGIC_ID2, ghp_pkg::METHOD_DEFLATE,
                            rand_byte(),
                            $urandom_range(0, 8), $urandom_range(0, 4), $urandom_range(0, 4),
                            $urandom_range(0, 3) != 0, -1, 1'b0,
                            $urandom_range(0, 1), $urandom_range(0, 2), 1'b1, 1'b0);
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (words_accepted < words_queued || expected_results.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
